>>> hw/rtl/ssp_pkg.sv
// shared types and constants for the single-source shortest path unit
`timescale 1ns / 1ps
`default_nettype none
package ssp_pkg;

  // fixed field widths
  localparam int DIST_W   = 32;
  localparam int VTX_W    = 6;
  localparam int VCNT_W   = 7;
  localparam int ECNT_W   = 9;
  localparam int EIDX_W   = 8;
  localparam int WFIELD_W = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [1:0] REG_EDGE_COUNT    = 2'd1;
  localparam logic [1:0] REG_SOURCE_VERTEX = 2'd2;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // outcome of one edge relaxation step
  typedef struct packed {
    logic                     relax;
    logic signed [DIST_W-1:0] cand;
  } relax_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/ssp_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hw/rtl/ssp_relax.sv
// relaxation datapath: saturating candidate distance and improvement test
`timescale 1ns / 1ps
`default_nettype none
module ssp_relax (
  input  wire logic signed [ssp_pkg::DIST_W-1:0] dist_u,
  input  wire logic signed [ssp_pkg::DIST_W-1:0] dist_v,
  input  wire logic signed [ssp_pkg::DIST_W-1:0] weight,
  input  wire logic                               tail_ok,
  input  wire logic                               head_ok,
  input  wire logic                               head_reached,
  output ssp_pkg::relax_res_t                     res
);
  import ssp_pkg::*;

  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;

  // wide sum, saturated to the signed 32-bit range
  assign sum = {dist_u[DIST_W-1], dist_u} + {weight[DIST_W-1], weight};

  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  // with a valid tail and head, an unreached head always improves
  assign res.cand  = cand;
  assign res.relax = tail_ok && head_ok && (!head_reached || (cand < dist_v));

endmodule
`default_nettype wire

>>> hw/rtl/single_source_shortest_paths_unit.sv
// top level: edge store, distance memory and Bellman-Ford sequencer
//
// Usage:
//   Items enter on start/in_* and are taken when start is high and busy is low.
//   A load item (in_command = 0) writes one edge into the edge store in the
//   cycle it is taken and gives no result; loads may follow each other every
//   cycle. A run item (in_command = 1) raises busy, makes nv-1 relaxation
//   passes and one check pass over ne edges (nv, ne the vertex and edge counts
//   in use), then emits one result per vertex in use on consecutive cycles,
//   flagged by out_valid, with out_last on the highest vertex. The receiver
//   cannot stall: each result is on the out_ ports for exactly one cycle.
//   Each edge visit goes through edge store read, distance memory read, then
//   compare and write back; visits do not overlap.
//   Registers sit on the APB-style port at byte addresses 0, 4 and 8; the user
//   must write them only while busy is low, which the block does not enforce.
//   Reset (rst_n low, synchronous) returns the registers to their reset values
//   and the sequencer to idle; edge store contents stay unknown until loaded.
`timescale 1ns / 1ps
`default_nettype none
module single_source_shortest_paths_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_command,
  input  wire logic        [ssp_pkg::EIDX_W-1:0]   in_edge_index,
  input  wire logic        [ssp_pkg::VTX_W-1:0]    in_edge_from,
  input  wire logic        [ssp_pkg::VTX_W-1:0]    in_edge_to,
  input  wire logic signed [ssp_pkg::WFIELD_W-1:0] in_edge_weight,
  // result channel
  output logic                                     out_valid,
  output logic             [ssp_pkg::VTX_W-1:0]    out_vertex,
  output logic signed      [ssp_pkg::DIST_W-1:0]   out_distance,
  output logic                                     out_reachable,
  output logic                                     out_negative_cycle,
  output logic                                     out_last,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [ssp_pkg::PADDR_W-1:0]  paddr,
  input  wire logic        [ssp_pkg::PDATA_W-1:0]  pwdata,
  output logic             [ssp_pkg::PDATA_W-1:0]  prdata,
  output logic                                     pready
);
  import ssp_pkg::*;

  localparam int WB   = (WEIGHT_BITS < WFIELD_W) ? WEIGHT_BITS : WFIELD_W;
  localparam int EW   = 2 * VTX_W + WB;
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NE_W = $clog2(MAX_EDGES + 1);
  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int NV_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_EREAD, S_DREAD, S_RELAX, S_EMIT, S_DRAIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic [VCNT_W-1:0] vertex_count_r;
  logic [ECNT_W-1:0] edge_count_r;
  logic [VTX_W-1:0]  source_vertex_r;

  // sequencer registers
  logic [NE_W-1:0]         edge_j_r;
  logic [NV_W-1:0]         pass_r;
  logic [NV_W-1:0]         vtx_k_r;
  logic                    cyc_r;
  logic [MAX_VERTICES-1:0] reached_r;
  logic                    emit_vld_r;
  logic                    emit_last_r;
  logic [NV_W-1:0]         emit_k_r;
  logic                    out_valid_r;

  // payload registers
  logic [VTX_W-1:0]         e_tail_r;
  logic [VTX_W-1:0]         e_head_r;
  logic signed [DIST_W-1:0] e_weight_r;
  logic [VTX_W-1:0]         out_vertex_r;
  logic signed [DIST_W-1:0] out_distance_r;
  logic                     out_reachable_r;
  logic                     out_negative_cycle_r;
  logic                     out_last_r;

  logic [NV_W-1:0]  nv;
  logic [NE_W-1:0]  ne;
  logic             src_ok;
  logic             apply;
  logic             in_take;
  logic             cfg_we;
  logic             edge_we;
  logic [EW-1:0]    edge_rd;
  logic [VA_W-1:0]  dist_raddr_a;
  logic [VA_W-1:0]  dist_raddr_b;
  logic             dist_we;
  logic [VA_W-1:0]  dist_waddr;
  logic [DIST_W-1:0] dist_wdata;
  logic [DIST_W-1:0] dist_rd_a;
  logic [DIST_W-1:0] dist_rd_b;
  logic             tail_ok;
  logic             head_ok;
  relax_res_t       rel;

  // counts in use, saturated to the built sizes; a vertex count of zero counts as one
  always_comb begin
    if (vertex_count_r == '0) begin
      nv = NV_W'(1);
    end else if (32'(vertex_count_r) > 32'(MAX_VERTICES)) begin
      nv = NV_W'(MAX_VERTICES);
    end else begin
      nv = NV_W'(vertex_count_r);
    end
    if (32'(edge_count_r) > 32'(MAX_EDGES)) begin
      ne = NE_W'(MAX_EDGES);
    end else begin
      ne = NE_W'(edge_count_r);
    end
  end

  assign src_ok  = 32'(source_vertex_r) < 32'(nv);
  assign apply   = pass_r < nv;
  assign in_take = start && !busy;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r  <= VCNT_W'(1);
      edge_count_r    <= '0;
      source_vertex_r <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_VERTEX_COUNT:  vertex_count_r  <= pwdata[VCNT_W-1:0];
        REG_EDGE_COUNT:    edge_count_r    <= pwdata[ECNT_W-1:0];
        REG_SOURCE_VERTEX: source_vertex_r <= pwdata[VTX_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VERTEX_COUNT:  prdata = PDATA_W'(vertex_count_r);
      REG_EDGE_COUNT:    prdata = PDATA_W'(edge_count_r);
      REG_SOURCE_VERTEX: prdata = PDATA_W'(source_vertex_r);
      default:           prdata = '0;
    endcase
  end

  // edge store: written by load items, read once per edge visit
  assign edge_we = in_take && (in_command == CMD_LOAD)
                   && (32'(in_edge_index) < 32'(MAX_EDGES));

  ssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (EA_W'(in_edge_index)),
    .wdata ({in_edge_from, in_edge_to, in_edge_weight[WB-1:0]}),
    .raddr (edge_j_r[EA_W-1:0]),
    .rdata (edge_rd)
  );

  // distance memory, mirrored so tail and head read in the same cycle
  assign dist_raddr_a = (state_r == S_EMIT) ? vtx_k_r[VA_W-1:0]
                                            : VA_W'(edge_rd[EW-1 -: VTX_W]);
  assign dist_raddr_b = VA_W'(edge_rd[EW-VTX_W-1 -: VTX_W]);

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = VA_W'(e_head_r);
    dist_wdata = rel.cand;
    case (state_r)
      S_INIT: begin
        dist_we    = src_ok;
        dist_waddr = VA_W'(source_vertex_r);
        dist_wdata = '0;
      end
      S_RELAX: begin
        dist_we = apply && rel.relax;
      end
      default: ;
    endcase
  end

  ssp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram_a (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr_a),
    .rdata (dist_rd_a)
  );

  ssp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram_b (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr_b),
    .rdata (dist_rd_b)
  );

  // endpoint checks; out-of-range vertices and an unreached tail skip the edge
  assign tail_ok = (32'(e_tail_r) < 32'(nv)) && reached_r[VA_W'(e_tail_r)];
  assign head_ok = 32'(e_head_r) < 32'(nv);

  ssp_relax u_relax (
    .dist_u       (dist_rd_a),
    .dist_v       (dist_rd_b),
    .weight       (e_weight_r),
    .tail_ok      (tail_ok),
    .head_ok      (head_ok),
    .head_reached (head_ok && reached_r[VA_W'(e_head_r)]),
    .res          (rel)
  );

  // sequencer: init, passes over the edges, then result emission
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      edge_j_r    <= '0;
      pass_r      <= '0;
      vtx_k_r     <= '0;
      cyc_r       <= 1'b0;
      reached_r   <= '0;
      emit_vld_r  <= 1'b0;
      emit_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      emit_vld_r  <= (state_r == S_EMIT);
      emit_last_r <= (state_r == S_EMIT) && (NV_W'(vtx_k_r + 1'b1) == nv);
      out_valid_r <= emit_vld_r;
      case (state_r)
        S_IDLE: begin
          if (in_take && (in_command == CMD_RUN)) begin
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          // only the source starts reached, and only if it is in use
          reached_r <= src_ok ? (MAX_VERTICES'(1) << source_vertex_r) : '0;
          edge_j_r  <= '0;
          pass_r    <= NV_W'(1);
          vtx_k_r   <= '0;
          cyc_r     <= 1'b0;
          state_r   <= (ne == '0) ? S_EMIT : S_EREAD;
        end
        S_EREAD: begin
          state_r <= S_DREAD;
        end
        S_DREAD: begin
          state_r <= S_RELAX;
        end
        S_RELAX: begin
          if (rel.relax) begin
            if (apply) begin
              reached_r[VA_W'(e_head_r)] <= 1'b1;
            end else begin
              cyc_r <= 1'b1;
            end
          end
          if (NE_W'(edge_j_r + 1'b1) == ne) begin
            edge_j_r <= '0;
            if (apply) begin
              pass_r  <= NV_W'(pass_r + 1'b1);
              state_r <= S_EREAD;
            end else begin
              state_r <= S_EMIT;
            end
          end else begin
            edge_j_r <= NE_W'(edge_j_r + 1'b1);
            state_r  <= S_EREAD;
          end
        end
        S_EMIT: begin
          vtx_k_r <= NV_W'(vtx_k_r + 1'b1);
          if (NV_W'(vtx_k_r + 1'b1) == nv) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // edge fields and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_DREAD) begin
      e_tail_r   <= edge_rd[EW-1 -: VTX_W];
      e_head_r   <= edge_rd[EW-VTX_W-1 -: VTX_W];
      e_weight_r <= {{(DIST_W-WB){edge_rd[WB-1]}}, edge_rd[WB-1:0]};
    end
    emit_k_r <= vtx_k_r;
    if (emit_vld_r) begin
      out_vertex_r         <= VTX_W'(emit_k_r);
      out_reachable_r      <= reached_r[emit_k_r[VA_W-1:0]];
      out_distance_r       <= reached_r[emit_k_r[VA_W-1:0]] ? dist_rd_a : '0;
      out_negative_cycle_r <= cyc_r;
      out_last_r           <= emit_last_r;
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_vertex         = out_vertex_r;
  assign out_distance       = out_distance_r;
  assign out_reachable      = out_reachable_r;
  assign out_negative_cycle = out_negative_cycle_r;
  assign out_last           = out_last_r;

  // results of a run come on consecutive cycles until the last
  a_emit_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("result burst broken before last item");

  // vertex numbers step by one through a run
  a_vertex_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_vertex == VTX_W'($past(out_vertex) + 1'b1))
    else $error("result vertex out of order");

  // a run stays busy until its last result is out
  a_busy_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("busy dropped while results remain");

  // run init leaves at most the source reached
  a_init_reached: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |=> $countones(reached_r) <= 1)
    else $error("reached flags not cleared at run start");

  // the edge store is never written while a run is active
  a_no_load_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELAX || state_r == S_DREAD) |-> !edge_we)
    else $error("edge store written during a run");

endmodule
`default_nettype wire

>>> tb/single_source_shortest_paths_unit_checker.sv
// checker for the shortest path unit: mirrors loads and registers, predicts and compares distances
`timescale 1ns / 1ps
module single_source_shortest_paths_unit_checker #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic                                    busy,
  input  logic                                    in_command,
  input  logic        [ssp_pkg::EIDX_W-1:0]       in_edge_index,
  input  logic        [ssp_pkg::VTX_W-1:0]        in_edge_from,
  input  logic        [ssp_pkg::VTX_W-1:0]        in_edge_to,
  input  logic signed [ssp_pkg::WFIELD_W-1:0]     in_edge_weight,
  input  logic                                    out_valid,
  input  logic        [ssp_pkg::VTX_W-1:0]        out_vertex,
  input  logic signed [ssp_pkg::DIST_W-1:0]       out_distance,
  input  logic                                    out_reachable,
  input  logic                                    out_negative_cycle,
  input  logic                                    out_last,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic                                    pready,
  input  logic        [ssp_pkg::PADDR_W-1:0]      paddr,
  input  logic        [ssp_pkg::PDATA_W-1:0]      pwdata,
  output int unsigned                             outstanding,
  output int unsigned                             mismatch_count,
  output int unsigned                             distances_checked
);
  import ssp_pkg::*;

  localparam longint DIST_MAX = 64'sd2147483647;
  localparam longint DIST_MIN = -64'sd2147483648;

  typedef struct {
    logic        [VTX_W-1:0]  vertex;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     last;
  } vertex_distance_t;

  // mirrored edge store and registers
  logic        [VTX_W-1:0]  arc_tail   [MAX_EDGES];
  logic        [VTX_W-1:0]  arc_head   [MAX_EDGES];
  logic signed [DIST_W-1:0] arc_weight [MAX_EDGES];
  logic        [VCNT_W-1:0] vertex_count_reg;
  logic        [ECNT_W-1:0] edge_count_reg;
  logic        [VTX_W-1:0]  source_reg;

  // working distances of the run being predicted
  logic signed [DIST_W-1:0] best_dist [MAX_VERTICES];
  bit                       reached   [MAX_VERTICES];

  vertex_distance_t pending_distances [$];
  vertex_distance_t want;

  task automatic flag_mismatch(input string what, input int vtx, input longint got,
                               input longint wanted);
    mismatch_count++;
    $display("[%0t] mismatch on %s at vertex %0d: got %0d, expected %0d",
             $time, what, vtx, got, wanted);
  endtask

  // one pass over the edges, relaxing when apply is set; tells whether any edge could relax
  function automatic bit sweep_edges(input int nv, input int ne, input bit apply);
    bit                       any;
    int                       u;
    int                       v;
    longint                   sum;
    logic signed [DIST_W-1:0] cand;
    any = 1'b0;
    for (int j = 0; j < ne; j++) begin
      u = int'(arc_tail[j]);
      v = int'(arc_head[j]);
      // unreached tails and endpoints beyond the vertices in use are skipped
      if (u >= nv || v >= nv || !reached[u]) continue;
      sum = longint'(best_dist[u]) + longint'(arc_weight[j]);
      if (sum > DIST_MAX) cand = DIST_MAX[DIST_W-1:0];
      else if (sum < DIST_MIN) cand = DIST_MIN[DIST_W-1:0];
      else cand = sum[DIST_W-1:0];
      if (!reached[v] || cand < best_dist[v]) begin
        any = 1'b1;
        if (apply) begin
          best_dist[v] = cand;
          reached[v]   = 1'b1;
        end
      end
    end
    return any;
  endfunction

  // full Bellman-Ford run, queues one expected distance per vertex in use
  function automatic void predict_distances();
    int               nv;
    int               ne;
    bit               cyc;
    vertex_distance_t r;
    nv = (vertex_count_reg == 0) ? 1 :
         (vertex_count_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_reg);
    ne = (edge_count_reg > MAX_EDGES) ? MAX_EDGES : int'(edge_count_reg);
    for (int k = 0; k < MAX_VERTICES; k++) begin
      best_dist[k] = '0;
      reached[k]   = 1'b0;
    end
    // a source outside the vertices in use reaches nothing
    if (source_reg < nv) reached[source_reg] = 1'b1;
    for (int p = 1; p < nv; p++) void'(sweep_edges(nv, ne, 1'b1));
    cyc = sweep_edges(nv, ne, 1'b0);
    for (int k = 0; k < nv; k++) begin
      r.vertex         = VTX_W'(k);
      r.distance       = reached[k] ? best_dist[k] : '0;
      r.reachable      = reached[k];
      r.negative_cycle = cyc;
      r.last           = (k == nv - 1);
      pending_distances.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_reg = VCNT_W'(1);
      edge_count_reg   = '0;
      source_reg       = '0;
      pending_distances.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_VERTEX_COUNT:  vertex_count_reg = pwdata[VCNT_W-1:0];
          REG_EDGE_COUNT:    edge_count_reg   = pwdata[ECNT_W-1:0];
          REG_SOURCE_VERTEX: source_reg       = pwdata[VTX_W-1:0];
          default: ;
        endcase
      end
      // accepted items
      if (start && !busy) begin
        if (in_command == CMD_LOAD) begin
          if (int'(in_edge_index) < MAX_EDGES) begin
            arc_tail[in_edge_index]   = in_edge_from;
            arc_head[in_edge_index]   = in_edge_to;
            arc_weight[in_edge_index] = in_edge_weight;
          end
        end else begin
          predict_distances();
        end
      end
      // results against the oldest expectation
      if (out_valid) begin
        if (pending_distances.size() == 0) begin
          flag_mismatch("result with nothing pending", int'(out_vertex),
                        longint'(out_distance), 64'sd0);
        end else begin
          want = pending_distances.pop_front();
          distances_checked++;
          if (out_vertex !== want.vertex)
            flag_mismatch("vertex", int'(want.vertex), longint'(out_vertex),
                          longint'(want.vertex));
          if (out_distance !== want.distance)
            flag_mismatch("distance", int'(want.vertex), longint'(out_distance),
                          longint'(want.distance));
          if (out_reachable !== want.reachable)
            flag_mismatch("reachable", int'(want.vertex), longint'(out_reachable),
                          longint'(want.reachable));
          if (out_negative_cycle !== want.negative_cycle)
            flag_mismatch("negative_cycle", int'(want.vertex), longint'(out_negative_cycle),
                          longint'(want.negative_cycle));
          if (out_last !== want.last)
            flag_mismatch("last", int'(want.vertex), longint'(out_last),
                          longint'(want.last));
        end
      end
    end
    outstanding <= pending_distances.size();
  end

endmodule

>>> tb/single_source_shortest_paths_unit_tb.sv
// testbench top for the shortest path unit: clock, reset, edge loads, runs and register writes
`timescale 1ns / 1ps
module single_source_shortest_paths_unit_tb;
  import ssp_pkg::*;

  logic                        clk                = 1'b0;
  logic                        rst_n              = 1'b0;
  logic                        start              = 1'b0;
  logic                        busy;
  logic                        in_command         = CMD_LOAD;
  logic        [EIDX_W-1:0]    in_edge_index      = '0;
  logic        [VTX_W-1:0]     in_edge_from       = '0;
  logic        [VTX_W-1:0]     in_edge_to         = '0;
  logic signed [WFIELD_W-1:0]  in_edge_weight     = '0;
  logic                        out_valid;
  logic        [VTX_W-1:0]     out_vertex;
  logic signed [DIST_W-1:0]    out_distance;
  logic                        out_reachable;
  logic                        out_negative_cycle;
  logic                        out_last;
  logic                        psel               = 1'b0;
  logic                        penable            = 1'b0;
  logic                        pwrite             = 1'b0;
  logic        [PADDR_W-1:0]   paddr              = '0;
  logic        [PDATA_W-1:0]   pwdata             = '0;
  logic        [PDATA_W-1:0]   prdata;
  logic                        pready;

  int unsigned outstanding;
  int unsigned mismatch_count;
  int unsigned distances_checked;

  int unsigned items_sent = 0;
  int unsigned runs_sent  = 0;
  int          idle_pct   = 24;
  bit          loaded [256];

  single_source_shortest_paths_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_edge_index      (in_edge_index),
    .in_edge_from       (in_edge_from),
    .in_edge_to         (in_edge_to),
    .in_edge_weight     (in_edge_weight),
    .out_valid          (out_valid),
    .out_vertex         (out_vertex),
    .out_distance       (out_distance),
    .out_reachable      (out_reachable),
    .out_negative_cycle (out_negative_cycle),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  single_source_shortest_paths_unit_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_edge_index      (in_edge_index),
    .in_edge_from       (in_edge_from),
    .in_edge_to         (in_edge_to),
    .in_edge_weight     (in_edge_weight),
    .out_valid          (out_valid),
    .out_vertex         (out_vertex),
    .out_distance       (out_distance),
    .out_reachable      (out_reachable),
    .out_negative_cycle (out_negative_cycle),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .outstanding        (outstanding),
    .mismatch_count     (mismatch_count),
    .distances_checked  (distances_checked)
  );

  always #5 clk = ~clk;

  // hand one item over, with random idle cycles before it
  task automatic send_item(input logic cmd, input logic [EIDX_W-1:0] idx,
                           input logic [VTX_W-1:0] from, input logic [VTX_W-1:0] to,
                           input logic signed [WFIELD_W-1:0] w);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_edge_index  <= idx;
    in_edge_from   <= from;
    in_edge_to     <= to;
    in_edge_weight <= w;
    do @(posedge clk); while (busy);
    items_sent++;
    if (cmd == CMD_RUN) runs_sent++;
  endtask

  task automatic load_edge(input int idx, input logic [VTX_W-1:0] from,
                           input logic [VTX_W-1:0] to, input logic signed [WFIELD_W-1:0] w);
    send_item(CMD_LOAD, EIDX_W'(idx), from, to, w);
    loaded[idx] = 1'b1;
  endtask

  task automatic run_paths();
    send_item(CMD_RUN, EIDX_W'($urandom_range(0, 255)), VTX_W'($urandom_range(0, 63)),
              VTX_W'($urandom_range(0, 63)), WFIELD_W'($urandom_range(0, 65535)));
  endtask

  // stop issuing and wait until every distance is back and the unit is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_graph(input logic [VCNT_W-1:0] vc, input logic [ECNT_W-1:0] ec,
                           input logic [VTX_W-1:0] src);
    drain();
    write_reg(REG_VERTEX_COUNT, PDATA_W'(vc));
    write_reg(REG_EDGE_COUNT, PDATA_W'(ec));
    write_reg(REG_SOURCE_VERTEX, PDATA_W'(src));
  endtask

  // mostly endpoints among the vertices in use, sometimes anywhere
  function automatic logic [VTX_W-1:0] pick_vertex(input int nv);
    if ($urandom_range(99) < 88) return VTX_W'($urandom_range(0, nv - 1));
    return VTX_W'($urandom_range(0, 63));
  endfunction

  // mostly small positive weights, some small negative ones, some anywhere in range
  function automatic logic signed [WFIELD_W-1:0] pick_weight();
    int roll;
    int w;
    roll = $urandom_range(99);
    if (roll < 65) w = $urandom_range(0, 60);
    else if (roll < 85) w = -int'($urandom_range(1, 12));
    else w = int'($urandom_range(0, 65535)) - 32768;
    return WFIELD_W'(w);
  endfunction

  // one graph: load its edges, program the counts and run it, sometimes twice
  task automatic run_episode();
    int                nv;
    int                ne;
    int                roll;
    logic [VCNT_W-1:0] vc_val;
    logic [VTX_W-1:0]  src_val;
    nv = ($urandom_range(99) < 6) ? 64 : $urandom_range(1, 8);
    ne = $urandom_range(0, 16);
    for (int i = 0; i < ne; i++)
      if (!loaded[i] || $urandom_range(99) < 55)
        load_edge(i, pick_vertex(nv), pick_vertex(nv), pick_weight());
    // stray load anywhere in the store
    if ($urandom_range(99) < 30)
      load_edge(int'($urandom_range(0, 255)), VTX_W'($urandom_range(0, 63)),
                VTX_W'($urandom_range(0, 63)), WFIELD_W'($urandom_range(0, 65535)));
    roll = $urandom_range(99);
    if (roll < 85) vc_val = VCNT_W'(nv);
    else if (roll < 92) vc_val = '0;
    else vc_val = VCNT_W'($urandom_range(65, 127));
    src_val = ($urandom_range(99) < 85) ? VTX_W'($urandom_range(0, nv - 1))
                                        : VTX_W'($urandom_range(0, 63));
    set_graph(vc_val, ECNT_W'(ne), src_val);
    run_paths();
    if ($urandom_range(99) < 25) run_paths();
  endtask

  initial begin
    int unsigned rand_base;
    int unsigned done_items;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // run on reset settings: single vertex, no edges
    run_paths();

    // small graph with out-of-range endpoints and extreme weights
    load_edge(0, 6'd0, 6'd1, 16'sd5);
    load_edge(1, 6'd1, 6'd2, -16'sd3);
    load_edge(2, 6'd0, 6'd2, 16'sd32767);
    load_edge(3, 6'd2, 6'd3, -16'sd32768);
    load_edge(4, 6'd63, 6'd0, 16'sd1);
    load_edge(5, 6'd3, 6'd63, 16'sd7);
    load_edge(6, 6'd3, 6'd1, 16'sd2);
    load_edge(255, 6'd63, 6'd63, -16'sd1);

    set_graph(7'd4, 9'd6, 6'd0);
    run_paths();
    // closing edge makes a negative cycle
    set_graph(7'd4, 9'd7, 6'd0);
    run_paths();
    set_graph(7'd4, 9'd7, 6'd3);
    run_paths();
    // source beyond the vertices in use
    set_graph(7'd4, 9'd7, 6'd5);
    run_paths();
    // vertex count of zero saturates to one
    set_graph(7'd0, 9'd7, 6'd0);
    run_paths();
    // oversized vertex count saturates to the maximum
    set_graph(7'd127, 9'd7, 6'd63);
    run_paths();
    set_graph(7'd64, 9'd0, 6'd63);
    run_paths();

    // random graphs, sender idling 24 then 62 then 0 percent
    rand_base = items_sent;
    while (items_sent < rand_base + 144) begin
      done_items = items_sent - rand_base;
      idle_pct = (done_items < 48) ? 24 : (done_items < 96) ? 62 : 0;
      run_episode();
    end

    drain();
    repeat (16) @(posedge clk);
    $display("covered %0d items (%0d runs) over several vertex and edge count settings",
             items_sent, runs_sent);
    $display("%0d vertex distances compared, %0d mismatches", distances_checked,
             mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("single_source_shortest_paths_unit_tb: done, clean");
    end else begin
      $display("single_source_shortest_paths_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("timeout with %0d distances still pending", outstanding);
    $display("single_source_shortest_paths_unit_tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_ram.sv
hw/rtl/ssp_relax.sv
hw/rtl/single_source_shortest_paths_unit.sv
tb/single_source_shortest_paths_unit_checker.sv
tb/single_source_shortest_paths_unit_tb.sv
